### sv/assert_macros.svh
// Assertion macros shared by the rounded corner mask RTL.
// Plain text only; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define RCM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define RCM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/rcm_pkg.sv
// Shared constants and controller/datapath interface types for the
// rounded corner mask row generator. No dependencies.
package rcm_pkg;

  localparam int MAX_DIM_DEF = 512;

  // Field widths fixed by the interface.
  localparam int ROW_W      = 9;
  localparam int BYTE_W     = 8;
  localparam int BIDX_W     = 6;
  localparam int DIMCFG_W   = 10;
  localparam int RADIUS_W   = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  // Pixel position / length compare width (covers 512 and byte index * 8 + 8).
  localparam int LEN_W      = 10;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MASK_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_HEIGHT = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS      = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROUND_TOP   = 8'd3;

  // Register reset values.
  localparam logic [DIMCFG_W-1:0] RST_MASK_WIDTH  = 10'd512;
  localparam logic [DIMCFG_W-1:0] RST_MASK_HEIGHT = 10'd512;
  localparam logic [RADIUS_W-1:0] RST_RADIUS      = 16'd0;
  localparam logic                RST_ROUND_TOP   = 1'b1;

  typedef struct packed {
    logic load_row;   // capture requested row
    logic setup;      // register clamped width, height, radius
    logic decide;     // classify row, square d, clear counters
    logic sq_dy;      // square dy
    logic search;     // one inset step
    logic out_err;    // load the error word
    logic out_byte;   // load the next mask word
  } rcm_cmd_t;

  typedef struct packed {
    logic row_err;
    logic corner;
    logic search_done;
    logic last_byte;
    logic out_free;
  } rcm_status_t;

endpackage

### sv/rcm_ctrl.sv
// Sequencer for the rounded corner mask row generator.
// Depends on rcm_pkg (command and status structs).
module rcm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output rcm_pkg::rcm_cmd_t    cmd,
  input  rcm_pkg::rcm_status_t status
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DECIDE,
    ST_SQ_DY,
    ST_SEARCH,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_row = 1'b1;
          state_nxt    = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        if (status.row_err) begin
          // wait for the output register, then send the single error word
          if (status.out_free) begin
            cmd.out_err = 1'b1;
            state_nxt   = ST_IDLE;
          end
        end else if (status.corner) begin
          state_nxt = ST_SQ_DY;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_SQ_DY: begin
        cmd.sq_dy = 1'b1;
        state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        cmd.search = 1'b1;
        if (status.search_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.out_byte = 1'b1;
          if (status.last_byte) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

### sv/rcm_dpath.sv
// Datapath of the rounded corner mask row generator: config registers,
// clamping, shared squaring unit for the inset search, word builder, output register.
// Depends on rcm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rcm_dpath #(
  parameter int MAX_DIM = rcm_pkg::MAX_DIM_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [rcm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rcm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [rcm_pkg::ROW_W-1:0]       in_row_index,
  input  rcm_pkg::rcm_cmd_t               cmd,
  output rcm_pkg::rcm_status_t            status,
  input  logic                            out_stall,
  output logic                            out_valid,
  output logic [rcm_pkg::BYTE_W-1:0]      out_mask_byte,
  output logic [rcm_pkg::BIDX_W-1:0]      out_byte_index,
  output logic                            out_last_byte,
  output logic                            out_row_error
);

  localparam int LEN_W    = rcm_pkg::LEN_W;
  localparam int RADIUS_W = rcm_pkg::RADIUS_W;
  localparam int DIMCFG_W = rcm_pkg::DIMCFG_W;
  localparam int BYTE_W   = rcm_pkg::BYTE_W;
  localparam int BIDX_W   = rcm_pkg::BIDX_W;
  localparam int DIM_W    = $clog2(MAX_DIM + 1);
  localparam int RAD_W    = $clog2(MAX_DIM / 2 + 1);
  localparam int OP_W     = RAD_W + 1;
  localparam int PROD_W   = 2 * OP_W;
  localparam int SQ_W     = PROD_W + 1;

  // Configuration registers
  logic [DIMCFG_W-1:0] cfg_width_r;
  logic [DIMCFG_W-1:0] cfg_height_r;
  logic [RADIUS_W-1:0] cfg_radius_r;
  logic                cfg_round_top_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r     <= rcm_pkg::RST_MASK_WIDTH;
      cfg_height_r    <= rcm_pkg::RST_MASK_HEIGHT;
      cfg_radius_r    <= rcm_pkg::RST_RADIUS;
      cfg_round_top_r <= rcm_pkg::RST_ROUND_TOP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rcm_pkg::REG_MASK_WIDTH:  cfg_width_r     <= cfg_data[DIMCFG_W-1:0];
        rcm_pkg::REG_MASK_HEIGHT: cfg_height_r    <= cfg_data[DIMCFG_W-1:0];
        rcm_pkg::REG_RADIUS:      cfg_radius_r    <= cfg_data[RADIUS_W-1:0];
        rcm_pkg::REG_ROUND_TOP:   cfg_round_top_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Clamping of width, height and radius
  logic [DIM_W-1:0]    w_clamp, h_clamp;
  logic [RADIUS_W-1:0] rad_a, rad_b;

  always_comb begin
    if (cfg_width_r == '0) begin
      w_clamp = DIM_W'(1);
    end else if (cfg_width_r > DIMCFG_W'(MAX_DIM)) begin
      w_clamp = DIM_W'(MAX_DIM);
    end else begin
      w_clamp = cfg_width_r[DIM_W-1:0];
    end
    if (cfg_height_r == '0) begin
      h_clamp = DIM_W'(1);
    end else if (cfg_height_r > DIMCFG_W'(MAX_DIM)) begin
      h_clamp = DIM_W'(MAX_DIM);
    end else begin
      h_clamp = cfg_height_r[DIM_W-1:0];
    end
    rad_a = (cfg_radius_r > RADIUS_W'(w_clamp >> 1)) ? RADIUS_W'(w_clamp >> 1) : cfg_radius_r;
    rad_b = (rad_a > RADIUS_W'(h_clamp >> 1)) ? RADIUS_W'(h_clamp >> 1) : rad_a;
  end

  logic [rcm_pkg::ROW_W-1:0] row_r;
  logic [DIM_W-1:0]          w_r, h_r;
  logic [RAD_W-1:0]          r_r;

  always_ff @(posedge clk) begin
    if (cmd.load_row) begin
      row_r <= in_row_index;
    end
    if (cmd.setup) begin
      w_r <= w_clamp;
      h_r <= h_clamp;
      r_r <= rad_b[RAD_W-1:0];
    end
  end

  // Row classification
  logic [LEN_W-1:0] row_l, h_l, r_l, band_end, cy_full;
  logic             row_err, corner;

  always_comb begin
    row_l    = LEN_W'(row_r);
    h_l      = LEN_W'(h_r);
    r_l      = LEN_W'(r_r);
    band_end = h_l - r_l;
    row_err  = (row_l >= h_l);
    corner   = (r_r != '0) && ((row_l >= band_end) || (cfg_round_top_r && (row_l < r_l)));
    // distance from the nearer top or bottom edge of the mask
    cy_full  = (row_l < r_l) ? row_l : (h_l - row_l - LEN_W'(1));
  end

  // Inset search: one shared squaring unit
  logic [RAD_W-1:0]  cy_r, k_r;
  logic [PROD_W-1:0] dd_r, dyy_r;
  logic [OP_W-1:0]   d_op, dy_op, dx_op, mul_a;
  logic [PROD_W-1:0] mul_p;
  logic              hit, search_done;

  always_comb begin
    d_op  = {r_r, 1'b0};
    dy_op = d_op - {cy_r, 1'b0} - OP_W'(1);
    dx_op = d_op - {k_r, 1'b0} - OP_W'(1);
    if (cmd.decide) begin
      mul_a = d_op;
    end else if (cmd.sq_dy) begin
      mul_a = dy_op;
    end else begin
      mul_a = dx_op;
    end
    mul_p       = PROD_W'(mul_a) * PROD_W'(mul_a);
    hit         = (SQ_W'(mul_p) + SQ_W'(dyy_r)) <= SQ_W'(dd_r);
    search_done = (k_r == r_r) || hit;
  end

  // Word builder
  logic [BIDX_W-1:0] b_r;
  logic [DIM_W-1:0]  hi;
  logic [LEN_W-1:0]  byte_base, px;
  logic [BYTE_W-1:0] mask_byte;
  logic              last_byte;

  always_comb begin
    hi        = w_r - DIM_W'(k_r);
    byte_base = LEN_W'({b_r, 3'b000});
    mask_byte = '0;
    px        = byte_base;
    for (int i = 0; i < BYTE_W; i++) begin
      px = byte_base + LEN_W'(i);
      mask_byte[BYTE_W-1-i] = (px >= LEN_W'(k_r)) && (px < LEN_W'(hi));
    end
    last_byte = (byte_base + LEN_W'(BYTE_W)) >= LEN_W'(w_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      dd_r <= mul_p;
      cy_r <= cy_full[RAD_W-1:0];
      k_r  <= '0;
      b_r  <= '0;
    end
    if (cmd.sq_dy) begin
      dyy_r <= mul_p;
    end
    if (cmd.search && !search_done) begin
      k_r <= k_r + RAD_W'(1);
    end
    if (cmd.out_byte) begin
      b_r <= b_r + BIDX_W'(1);
    end
  end

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_mask_r;
  logic [BIDX_W-1:0] out_idx_r;
  logic              out_last_r, out_err_r;
  logic              out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    if (cmd.out_err || cmd.out_byte) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_err) begin
      out_mask_r <= '0;
      out_idx_r  <= '0;
      out_last_r <= 1'b1;
      out_err_r  <= 1'b1;
    end else if (cmd.out_byte) begin
      out_mask_r <= mask_byte;
      out_idx_r  <= b_r;
      out_last_r <= last_byte;
      out_err_r  <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_mask_byte  = out_mask_r;
  assign out_byte_index = out_idx_r;
  assign out_last_byte  = out_last_r;
  assign out_row_error  = out_err_r;

  always_comb begin
    status.row_err     = row_err;
    status.corner      = corner;
    status.search_done = search_done;
    status.last_byte   = last_byte;
    status.out_free    = out_free;
  end

  `RCM_ASSERT(a_search_bound, clk, rst_n, cmd.search |-> (k_r <= r_r), "inset passed the radius")
  `RCM_ASSERT(a_word_in_row, clk, rst_n, cmd.out_byte |-> (byte_base < LEN_W'(w_r)), "word past row end")

endmodule

### sv/rounded_corner_mask_rows_top.sv
// Rounded corner mask row generator. Each accepted row index yields that row of a
// 1-bit rounded-rectangle mask as (width+7)/8 words, leftmost pixel in bit 7, or a
// single error word for a row at or past the height. A corner row also runs the
// inset search, one candidate per cycle through the shared squaring multiplier,
// and a row waits while the output side stalls. Width, height and radius are
// clamped internally; config writes are always ready and must only occur while
// no row is in flight.
// Depends on rcm_pkg, rcm_ctrl, rcm_dpath and assert_macros.svh.
`include "assert_macros.svh"

module rounded_corner_mask_rows_top #(
  parameter int MAX_DIM = rcm_pkg::MAX_DIM_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rcm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rcm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [rcm_pkg::ROW_W-1:0]      in_row_index,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [rcm_pkg::BYTE_W-1:0]     out_mask_byte,
  output logic [rcm_pkg::BIDX_W-1:0]     out_byte_index,
  output logic                           out_last_byte,
  output logic                           out_row_error
);

  rcm_pkg::rcm_cmd_t    cmd;
  rcm_pkg::rcm_status_t status;

  assign cfg_ready = 1'b1;

  rcm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  rcm_dpath #(
    .MAX_DIM (MAX_DIM)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_row_index   (in_row_index),
    .cmd            (cmd),
    .status         (status),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_mask_byte  (out_mask_byte),
    .out_byte_index (out_byte_index),
    .out_last_byte  (out_last_byte),
    .out_row_error  (out_row_error)
  );

  `RCM_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "accepted row did not block input")
  `RCM_ASSERT(a_err_word, clk, rst_n, (out_valid && out_row_error) |-> (out_last_byte && (out_byte_index == '0) && (out_mask_byte == '0)), "malformed error word")

endmodule

### verif/rounded_corner_mask_rows_top_tb.sv
// Testbench for rounded_corner_mask_rows_top: directed and random row requests, with mask
// words predicted in the bench and checked against the block's output stream.
// Depends on rcm_pkg and the rounded_corner_mask_rows_top RTL.
`timescale 1ns / 1ps

module rounded_corner_mask_rows_top_tb;

  localparam int ROW_W       = rcm_pkg::ROW_W;
  localparam int BYTE_W      = rcm_pkg::BYTE_W;
  localparam int BIDX_W      = rcm_pkg::BIDX_W;
  localparam int DIMCFG_W    = rcm_pkg::DIMCFG_W;
  localparam int RADIUS_W    = rcm_pkg::RADIUS_W;
  localparam int CFG_IDX_W   = rcm_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W  = rcm_pkg::CFG_DATA_W;
  localparam int MAX_DIM_DEF = rcm_pkg::MAX_DIM_DEF;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned TAIL_CYCLES    = 40;
  localparam int unsigned MAX_REPORTS    = 40;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'hFF;

  typedef struct packed {
    logic [BYTE_W-1:0] mask_byte;
    logic [BIDX_W-1:0] byte_index;
    logic              last_byte;
    logic              row_error;
  } mask_word_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [ROW_W-1:0]      in_row_index = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [BYTE_W-1:0]     out_mask_byte;
  logic [BIDX_W-1:0]     out_byte_index;
  logic                  out_last_byte;
  logic                  out_row_error;

  // register copies kept by the bench
  logic [DIMCFG_W-1:0] width_setting     = rcm_pkg::RST_MASK_WIDTH;
  logic [DIMCFG_W-1:0] height_setting    = rcm_pkg::RST_MASK_HEIGHT;
  logic [RADIUS_W-1:0] radius_setting    = rcm_pkg::RST_RADIUS;
  logic                round_top_setting = rcm_pkg::RST_ROUND_TOP;

  mask_word_t  expected_words[$];
  mask_word_t  next_word;
  logic        idling = 1'b1;
  int unsigned mismatches = 0;
  int unsigned rows_sent = 0;
  int unsigned words_checked = 0;
  int unsigned corner_rows = 0;
  int unsigned error_rows = 0;
  int unsigned shapes = 0;
  int unsigned idle_cycles;

  rounded_corner_mask_rows_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_row_index   (in_row_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_mask_byte  (out_mask_byte),
    .out_byte_index (out_byte_index),
    .out_last_byte  (out_last_byte),
    .out_row_error  (out_row_error)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int unsigned dim_in_range(logic [DIMCFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
    return v;
  endfunction

  // Grow the inset until the pixel center falls inside the corner circle.
  function automatic int unsigned inset_for_row(int unsigned row, int unsigned h,
                                                int unsigned r);
    int unsigned cy, d, k, dx, dy;
    if (r == 0 || (row >= r && row < h - r)) return 0;
    cy = (row < r) ? row : h - row - 1;
    d = 2 * r;
    for (k = 0; k < r; k++) begin
      dx = d - 2 * k - 1;
      dy = d - 2 * cy - 1;
      if (dx * dx + dy * dy <= d * d) break;
    end
    return k;
  endfunction

  function automatic void predict_row_bytes(int unsigned row);
    int unsigned w, h, r, inset, pitch, px;
    mask_word_t word;
    w = dim_in_range(width_setting);
    h = dim_in_range(height_setting);
    if (row >= h) begin
      word = '0;
      word.last_byte = 1'b1;
      word.row_error = 1'b1;
      expected_words.push_back(word);
      error_rows++;
      return;
    end
    r = radius_setting;
    if (r > w / 2) r = w / 2;
    if (r > h / 2) r = h / 2;
    if (r == 0 || (!round_top_setting && row < h - r)) inset = 0;
    else inset = inset_for_row(row, h, r);
    if (inset != 0) corner_rows++;
    pitch = (w + 7) / 8;
    for (int b = 0; b < pitch; b++) begin
      word = '0;
      for (int bit_i = 0; bit_i < 8; bit_i++) begin
        px = b * 8 + bit_i;
        if (px >= inset && px < w - inset) word.mask_byte[7 - bit_i] = 1'b1;
      end
      word.byte_index = BIDX_W'(b);
      word.last_byte  = (b + 1 == pitch);
      expected_words.push_back(word);
    end
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
  endtask

  // Output stall in short random bursts.
  initial begin
    forever begin
      @(posedge clk);
      if (idling && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        report_mismatch("word with nothing expected, mask_byte", out_mask_byte, 0);
      end else begin
        next_word = expected_words.pop_front();
        words_checked++;
        if (out_mask_byte !== next_word.mask_byte)
          report_mismatch("mask_byte", out_mask_byte, next_word.mask_byte);
        if (out_byte_index !== next_word.byte_index)
          report_mismatch("byte_index", out_byte_index, next_word.byte_index);
        if (out_last_byte !== next_word.last_byte)
          report_mismatch("last_byte", out_last_byte, next_word.last_byte);
        if (out_row_error !== next_word.row_error)
          report_mismatch("row_error", out_row_error, next_word.row_error);
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("watchdog: no handshake for %0d cycles, %0d words pending", WATCHDOG_LIMIT,
             expected_words.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_row(input logic [ROW_W-1:0] row);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_row_index <= row;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_row_bytes(row);
    rows_sent++;
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_valid high so writes can go back to back; caller lowers it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      rcm_pkg::REG_MASK_WIDTH:  width_setting = data[DIMCFG_W-1:0];
      rcm_pkg::REG_MASK_HEIGHT: height_setting = data[DIMCFG_W-1:0];
      rcm_pkg::REG_RADIUS:      radius_setting = data[RADIUS_W-1:0];
      rcm_pkg::REG_ROUND_TOP:   round_top_setting = data[0];
      default: ;
    endcase
  endtask

  task automatic set_shape(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                           input logic [CFG_DATA_W-1:0] r, input logic top);
    wait_for_drain();
    write_reg(rcm_pkg::REG_MASK_WIDTH, w);
    write_reg(rcm_pkg::REG_MASK_HEIGHT, h);
    write_reg(rcm_pkg::REG_RADIUS, r);
    write_reg(rcm_pkg::REG_ROUND_TOP, {15'd0, top});
    cfg_valid <= 1'b0;
    shapes++;
  endtask

  task automatic apply_random_shape();
    logic [CFG_DATA_W-1:0] w, h, r;
    w = ($urandom_range(0, 7) == 0) ? CFG_DATA_W'($urandom())
                                    : CFG_DATA_W'($urandom_range(1, 40));
    h = ($urandom_range(0, 7) == 0) ? CFG_DATA_W'($urandom())
                                    : CFG_DATA_W'($urandom_range(1, 40));
    r = ($urandom_range(0, 7) == 0) ? CFG_DATA_W'($urandom())
                                    : CFG_DATA_W'($urandom_range(0, 24));
    set_shape(w, h, r, 1'($urandom_range(0, 1)));
  endtask

  // Mostly legal rows, biased toward the corner bands; some rows anywhere.
  function automatic logic [ROW_W-1:0] pick_row();
    int unsigned h, band;
    h = dim_in_range(height_setting);
    band = (h < 32) ? h : 32;
    case ($urandom_range(0, 9))
      0:       return ROW_W'($urandom_range(0, 511));
      1, 2:    return ROW_W'($urandom_range(0, band - 1));
      3, 4:    return ROW_W'(h - 1 - $urandom_range(0, band - 1));
      default: return ROW_W'($urandom_range(0, h - 1));
    endcase
  endfunction

  task automatic send_random_rows(input int unsigned count, input int pause_at);
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) wait_for_drain();
      send_row(pick_row());
    end
  endtask

  task automatic test_default_registers();
    send_row(9'd0);
    send_row(9'd511);
    send_row(9'h0AA);
    send_row(9'h155);
  endtask

  task automatic test_rows_past_height();
    set_shape(16'd20, 16'd10, 16'd0, 1'b1);
    send_row(9'd9);
    send_row(9'd10);
    send_row(9'd511);
  endtask

  // Zero dims read as one, oversized dims as the maximum, radius clamped to half.
  task automatic test_dimension_clamping();
    set_shape(16'd0, 16'd0, 16'd7, 1'b1);
    send_row(9'd0);
    send_row(9'd1);
    set_shape(16'h03FF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_row(9'd0);
    send_row(9'd255);
    send_row(9'd256);
    send_row(9'd511);
  endtask

  task automatic test_corner_rows();
    set_shape(16'd24, 16'd16, 16'd5, 1'b1);
    send_row(9'd0);
    send_row(9'd4);
    send_row(9'd5);
    send_row(9'd10);
    send_row(9'd11);
    send_row(9'd15);
  endtask

  task automatic test_square_top();
    set_shape(16'd24, 16'd16, 16'd5, 1'b0);
    send_row(9'd0);
    send_row(9'd10);
    send_row(9'd11);
    send_row(9'd15);
  endtask

  task automatic test_unmapped_register();
    wait_for_drain();
    write_reg(REG_UNMAPPED, 16'hFFFF);
    cfg_valid <= 1'b0;
    send_row(9'd0);
  endtask

  task automatic test_random_shapes();
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: set_shape(16'd512, 16'd512, CFG_DATA_W'($urandom()), 1'($urandom_range(0, 1)));
        1: set_shape(16'd1, CFG_DATA_W'($urandom_range(1, 40)), 16'hFFFF, 1'b1);
        default: apply_random_shape();
      endcase
      idling = ($urandom_range(0, 3) != 0);
      send_random_rows(45, (phase == 3) ? 20 : -1);
    end
  endtask

  task automatic test_quiet_tail();
    apply_random_shape();
    idling = 1'b0;
    send_random_rows(30, -1);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_default_registers();
    test_rows_past_height();
    test_dimension_clamping();
    test_corner_rows();
    test_square_top();
    test_unmapped_register();
    test_random_shapes();
    test_quiet_tail();
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_words.size() != 0)
      report_mismatch("words never delivered", expected_words.size(), 0);
    $display("covered %0d row requests over %0d register settings, %0d mask words checked",
             rows_sent, shapes, words_checked);
    $display("%0d rows had a corner inset, %0d rows fell past the height, %0d mismatches",
             corner_rows, error_rows, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/rcm_pkg.sv
sv/rcm_ctrl.sv
sv/rcm_dpath.sv
sv/rounded_corner_mask_rows_top.sv
verif/rounded_corner_mask_rows_top_tb.sv
